>>> rtl/psched_pkg.sv
// Shared types and constants for the periodic slot scheduler.
// Item structs for both channels, command codes and the control struct
// passed to the slot bank. No dependencies.
package psched_pkg;

	localparam int unsigned TIME_W     = 32;
	localparam int unsigned PERIOD_W   = 23;
	localparam int unsigned NUM_REGS   = 4;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned MASK_W     = 4;

	localparam logic [TIME_W-1:0] TICK_US     = 32'd1000;
	localparam logic [TIME_W-1:0] MIN_LEAD_US = 32'd50;
	localparam logic [TIME_W-1:0] RECOVER_US  = 32'd15;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_TICK  = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [TIME_W-1:0] now_time;
		logic [TIME_W-1:0] scheduled_time;
		logic [TIME_W-1:0] finish_time;
	} in_item_t;

	typedef struct packed {
		logic [MASK_W-1:0] due_mask;
		logic [TIME_W-1:0] next_alarm;
		logic              overrun;
		logic [TIME_W-1:0] overrun_count;
		logic [TIME_W-1:0] max_tick_duration;
	} out_item_t;

	// Per-item request to the slot bank
	typedef struct packed {
		logic              start;
		logic              tick;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] sched;
	} slot_op_t;

endpackage

>>> rtl/periodic_slot_scheduler.sv
// Periodic slot scheduler, top level: input register, slot bank,
// alarm and statistics logic, result register.
// Depends on psched_pkg and psched_slot_bank.
//
//   channel  | signals                           | payload
//   ---------+-----------------------------------+----------------------------
//   input    | in_valid / in_ready               | in_item  (in_item_t)
//   result   | out_valid / out_ready             | out_item (out_item_t)
//   config   | cfg_we, cfg_index                 | cfg_data (slot period, ms)
//
// One item per cycle sustained while the result channel is not stalled; an
// accepted item is taken by the input register, then by the result register
// once that is empty or being drained. Each item is handled in a single pass
// of short logic between the two registers.
// A stalled result holds the result register; the input register keeps one
// more item, and in_ready falls only when both are full.
// Reset clears periods, last-run times, the overrun count and the longest
// tick, and empties both registers.
module periodic_slot_scheduler
	import psched_pkg::*;
#(
	parameter int unsigned NUM_SLOTS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PERIOD_W-1:0]  cfg_data
);

	logic              valid_s1;
	in_item_t          item_s1;
	logic              out_valid_q;
	out_item_t         out_item_q;
	logic [TIME_W-1:0] overrun_total_q;
	logic [TIME_W-1:0] longest_tick_q;

	logic                 advance;
	logic                 fire;
	slot_op_t             op;
	logic [NUM_SLOTS-1:0] due;
	logic [MASK_W-1:0]    due_mask;

	logic [TIME_W-1:0] next_nom;
	logic [TIME_W-1:0] gap;
	logic [TIME_W-1:0] dur;
	logic              late;
	logic              ovr;
	logic [TIME_W-1:0] next_alarm;
	logic [TIME_W-1:0] overrun_next;
	logic [TIME_W-1:0] longest_next;

	// Result register can take a new result when empty or being drained
	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// Hold the item in the input register until it can move on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// Slot bank updates last-run times only when the item fires
	always_comb begin
		op.start = fire && (item_s1.cmd == CMD_START);
		op.tick  = fire && (item_s1.cmd == CMD_TICK);
		op.now   = item_s1.now_time;
		op.sched = item_s1.scheduled_time;
	end

	psched_slot_bank #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_slots (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.op        (op),
		.due       (due)
	);

	// Only the first four slots are reported; pad when there are fewer
	for (genvar b = 0; b < MASK_W; b++) begin : g_mask
		if (b < NUM_SLOTS) begin : g_bit
			assign due_mask[b] = due[b];
		end else begin : g_pad
			assign due_mask[b] = 1'b0;
		end
	end

	// Tick alarm: a millisecond past scheduled, or just past finish if the lead over
	// finish is under the minimum or over one tick; a start: a millisecond past now
	always_comb begin
		next_nom     = item_s1.scheduled_time + TICK_US;
		gap          = next_nom - item_s1.finish_time;
		dur          = item_s1.finish_time - item_s1.now_time;
		late         = (gap < MIN_LEAD_US) || (gap > TICK_US);
		ovr          = 1'b0;
		next_alarm   = item_s1.now_time + TICK_US;
		overrun_next = overrun_total_q;
		longest_next = longest_tick_q;
		if (item_s1.cmd == CMD_TICK) begin
			ovr        = late;
			next_alarm = late ? (item_s1.finish_time + RECOVER_US) : next_nom;
			if (late) begin
				overrun_next = overrun_total_q + 32'd1;
			end
			if (dur > longest_tick_q) begin
				longest_next = dur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overrun_total_q <= '0;
			longest_tick_q  <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (fire) begin
				overrun_total_q <= overrun_next;
				longest_tick_q  <= longest_next;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_item_q.due_mask          <= due_mask;
			out_item_q.next_alarm        <= next_alarm;
			out_item_q.overrun           <= ovr;
			out_item_q.overrun_count     <= overrun_next;
			out_item_q.max_tick_duration <= longest_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

>>> rtl/psched_slot_bank.sv
// Slot bank: per-slot period (held in microseconds) and last-run time.
// Depends on psched_pkg for the slot request struct and constants.
module psched_slot_bank
	import psched_pkg::*;
#(
	parameter int unsigned NUM_SLOTS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PERIOD_W-1:0]  cfg_data,
	input  slot_op_t             op,
	output logic [NUM_SLOTS-1:0] due
);

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
		localparam logic [TIME_W-1:0] STAGGER = TIME_W'(i * 1000);

		logic [TIME_W-1:0] per_us;
		logic [TIME_W-1:0] last_run_q;
		logic [TIME_W-1:0] elapsed;
		logic              hit;

		if (i < NUM_REGS) begin : g_reg
			logic [TIME_W-1:0] per_us_q;

			// convert to microseconds once, on the register write
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					per_us_q <= '0;
				end else if (cfg_we && cfg_index == CFG_IDX_W'(i)) begin
					per_us_q <= TIME_W'(TIME_W'(cfg_data) * TICK_US);
				end
			end
			assign per_us = per_us_q;
		end else begin : g_fixed
			assign per_us = '0;
		end

		assign elapsed = op.now - last_run_q;
		assign hit     = op.tick && (elapsed > per_us);
		assign due[i]  = hit;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				last_run_q <= '0;
			end else if (op.start) begin
				last_run_q <= op.now - STAGGER;
			end else if (hit) begin
				last_run_q <= op.sched;
			end
		end
	end

endmodule

>>> tb/psched_checker.sv
// Result checker for the periodic slot scheduler: tracks period writes and
// accepted items, predicts each result and compares what leaves the block.
// Depends on psched_pkg.
module psched_checker
	import psched_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_item_t             in_item,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  out_item_t            out_item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PERIOD_W-1:0]  cfg_data,
	output int unsigned          errors,
	output int unsigned          pending
);

	logic [PERIOD_W-1:0] period_ms [NUM_REGS];
	logic [TIME_W-1:0]   last_run [NUM_REGS];
	logic [TIME_W-1:0]   overrun_total;
	logic [TIME_W-1:0]   longest_tick;
	out_item_t           alarm_results [$];
	out_item_t           oldest;

	// Advance the slot state by one item and return the result it gives
	function automatic out_item_t schedule_item(in_item_t it);
		out_item_t         res;
		logic [TIME_W-1:0] per_us;
		logic [TIME_W-1:0] elapsed;
		logic [TIME_W-1:0] lead;
		logic [TIME_W-1:0] dur;
		int                i;
		res = '0;
		if (it.cmd == CMD_START) begin
			for (i = 0; i < NUM_REGS; i++)
				last_run[i] = it.now_time - TIME_W'(i) * TICK_US;
			res.next_alarm = it.now_time + TICK_US;
		end else begin
			for (i = 0; i < NUM_REGS; i++) begin
				// 32-bit product: wraps for periods beyond the stated range
				per_us  = TIME_W'(period_ms[i]) * TICK_US;
				elapsed = it.now_time - last_run[i];
				if (elapsed > per_us) begin
					last_run[i]     = it.scheduled_time;
					res.due_mask[i] = 1'b1;
				end
			end
			res.next_alarm = it.scheduled_time + TICK_US;
			lead = res.next_alarm - it.finish_time;
			if (lead < MIN_LEAD_US || lead > TICK_US) begin
				overrun_total  = overrun_total + 1'b1;
				res.next_alarm = it.finish_time + RECOVER_US;
				res.overrun    = 1'b1;
			end
			dur = it.finish_time - it.now_time;
			if (dur > longest_tick)
				longest_tick = dur;
		end
		res.overrun_count     = overrun_total;
		res.max_tick_duration = longest_tick;
		return res;
	endfunction

	task automatic check_field(input string name, input logic [TIME_W-1:0] want,
			input logic [TIME_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				period_ms[i] = '0;
				last_run[i]  = '0;
			end
			overrun_total = '0;
			longest_tick  = '0;
			alarm_results.delete();
			pending <= 0;
		end else begin
			if (cfg_we && cfg_index < NUM_REGS)
				period_ms[cfg_index] = cfg_data;
			if (out_valid && out_ready) begin
				if (alarm_results.size() == 0) begin
					$display("%0t: result with nothing outstanding: expected none, actual %p",
						$time, out_item);
					errors++;
				end else begin
					oldest = alarm_results.pop_front();
					check_field("due_mask", TIME_W'(oldest.due_mask),
						TIME_W'(out_item.due_mask));
					check_field("next_alarm", oldest.next_alarm, out_item.next_alarm);
					check_field("overrun", TIME_W'(oldest.overrun), TIME_W'(out_item.overrun));
					check_field("overrun_count", oldest.overrun_count, out_item.overrun_count);
					check_field("max_tick_duration", oldest.max_tick_duration,
						out_item.max_tick_duration);
				end
			end
			if (in_valid && in_ready)
				alarm_results.push_back(schedule_item(in_item));
			pending <= alarm_results.size();
		end
	end

endmodule

>>> tb/tb.sv
// Top of the periodic slot scheduler testbench: clock, reset, period writes,
// start and tick items, result back-pressure and the final verdict.
// Depends on psched_pkg, periodic_slot_scheduler and psched_checker.
module tb;
	import psched_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned PHASE_ITEMS  = 375;
	localparam int unsigned NUM_PHASES   = 4;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_item_t             in_item   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_item;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [PERIOD_W-1:0]  cfg_data  = '0;

	int unsigned errors;
	int unsigned pending;
	int unsigned cycles     = 0;
	int unsigned items_sent = 0;
	int unsigned idle_pct   = 0;
	int unsigned stall_pct  = 0;

	// Idling per phase: none, sender only, receiver only, both
	int unsigned idle_by_phase  [NUM_PHASES] = '{0, 45, 0, 28};
	int unsigned stall_by_phase [NUM_PHASES] = '{0, 0, 45, 28};

	periodic_slot_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	psched_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always #2 clk = ~clk;

	// Give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Stall the result channel at the rate of the current phase
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic in_item_t make_item(input cmd_t c, input logic [TIME_W-1:0] now,
			input logic [TIME_W-1:0] sched, input logic [TIME_W-1:0] fin);
		in_item_t it;
		it.cmd            = c;
		it.now_time       = now;
		it.scheduled_time = sched;
		it.finish_time    = fin;
		return it;
	endfunction

	// Offer one item, with random idle cycles first, and hold it until taken.
	// Valid is left high on return so a back-to-back item needs no toggle.
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Drop valid and hold until every outstanding result has left the block
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all four period registers on consecutive cycles
	task automatic set_periods(input logic [PERIOD_W-1:0] p0, input logic [PERIOD_W-1:0] p1,
			input logic [PERIOD_W-1:0] p2, input logic [PERIOD_W-1:0] p3);
		logic [NUM_REGS-1:0][PERIOD_W-1:0] ms;
		ms = {p3, p2, p1, p0};
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= ms[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// A start followed by ticks that follow the alarm chain, as firmware would
	// see them, with the odd restart and some random noise mixed in
	task automatic run_sequence(input int unsigned count);
		in_item_t          it;
		logic [TIME_W-1:0] alarm;
		logic [TIME_W-1:0] lead;
		int unsigned       roll;
		// Start near the 32-bit wrap now and then
		if ($urandom_range(3) == 0)
			it = make_item(CMD_START, 32'hFFFF_FFFF - $urandom_range(20000), $urandom, $urandom);
		else
			it = make_item(CMD_START, $urandom, $urandom, $urandom);
		send_item(it);
		alarm = it.now_time + TICK_US;
		repeat (count) begin
			roll = $urandom_range(99);
			if (roll < 3) begin
				it    = make_item(CMD_START, alarm - $urandom_range(1000), $urandom, $urandom);
				alarm = it.now_time + TICK_US;
			end else if (roll < 10) begin
				it = make_item(cmd_t'($urandom_range(1)), $urandom, $urandom, $urandom);
			end else begin
				it.cmd            = CMD_TICK;
				it.scheduled_time = alarm;
				// Mostly prompt, sometimes handled late
				it.now_time = alarm + ((roll < 20) ? $urandom_range(5000) : $urandom_range(40));
				case ($urandom_range(9))
					0: it.finish_time = it.now_time + $urandom_range(200000);
					// straddle the minimum lead before the next alarm
					1: it.finish_time = alarm + TICK_US - MIN_LEAD_US - 5 + $urandom_range(10);
					default: it.finish_time = it.now_time + $urandom_range(600);
				endcase
				lead = alarm + TICK_US - it.finish_time;
				if (lead < MIN_LEAD_US || lead > TICK_US)
					alarm = it.finish_time + RECOVER_US;
				else
					alarm = alarm + TICK_US;
			end
			send_item(it);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: zero, one millisecond, top of range, all-ones wrap
		set_periods(0, 1, 4294967, 23'h7F_FFFF);
		// tick straight after reset: nothing elapsed, lead of exactly one tick
		send_item(make_item(CMD_TICK, 32'd0, 32'd0, 32'd0));
		// start ignores the scheduled and finish fields
		send_item(make_item(CMD_START, 32'd5000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_item(make_item(CMD_TICK, 32'd6000, 32'd6000, 32'd6100));
		// lead exactly at the minimum, then one below it
		send_item(make_item(CMD_TICK, 32'd7000, 32'd7000, 32'd7950));
		send_item(make_item(CMD_TICK, 32'd8000, 32'd8000, 32'd8951));
		// finish before the alarm it served: lead just over one tick
		send_item(make_item(CMD_TICK, 32'd9000, 32'd9000, 32'd8999));
		// finish exactly on the next alarm: zero lead
		send_item(make_item(CMD_TICK, 32'd10000, 32'd10000, 32'd11000));
		// finish before now: duration wraps to a huge value
		send_item(make_item(CMD_TICK, 32'd12000, 32'd12000, 32'd11990));
		// start just above zero so the staggered last-run times wrap
		send_item(make_item(CMD_START, 32'h0000_0100, 32'd0, 32'd0));
		// elapsed time just over the top-of-range period
		send_item(make_item(CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF8));
		send_item(make_item(CMD_START, 32'hFFFF_FFFF, 32'd0, 32'd0));
		send_item(make_item(CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_item(make_item(CMD_TICK, 32'd0, 32'd0, 32'd0));
		send_item(make_item(CMD_TICK, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
		send_item(make_item(CMD_TICK, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));

		// Random part: one period setting and one idling pattern per phase
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			drain();
			case (phase)
				0: set_periods(1, 2, 3, 0);
				1: set_periods(0, 1, 4, 2);
				2: set_periods(4294967, 23'h7F_FFFF, 1, 3);
				default: set_periods(PERIOD_W'($urandom_range(6)), PERIOD_W'($urandom_range(6)),
						PERIOD_W'($urandom_range(6)), PERIOD_W'($urandom_range(6)));
			endcase
			idle_pct   = idle_by_phase[phase];
			stall_pct  = stall_by_phase[phase];
			items_sent = 0;
			while (items_sent < PHASE_ITEMS)
				run_sequence($urandom_range(20, 120));
		end

		// Let the last results out, then give the final verdict
		drain();
		repeat (8) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
